>>> src/irt_pkg.sv
package irt_pkg;

  // Number of reserved ranges the table can hold.
  localparam int unsigned TABLE_SLOTS   = 16;
  // Width of one segment position.
  localparam int unsigned POSITION_BITS = 20;

  // Slot index width, and a scan counter that can also hold TABLE_SLOTS.
  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  // Request operation codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

endpackage

>>> src/interval_reservation_table_core.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+----------------------------------------
// request  | in        | in_valid_i / in_stall_o | op_i, range_start_i, range_end_i
// result   | out       | out_valid_o / out_stall_i | granted_o, freed_start_o, freed_end_o
//
// Every request steps through the table slots one at a time with the single slot
// comparator, each slot read from the registered memory, then updates the table
// and presents the result.
// Reset clears the slot valid bits and the sequencer; the range memory is not cleared.
// The request side is stalled from the transfer of a request until its result is taken.
// A stall on the result side holds the result and keeps the request side stalled.
module interval_reservation_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [irt_pkg::POSITION_BITS-1:0] range_start_i,
  input  logic [irt_pkg::POSITION_BITS-1:0] range_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              granted_o,
  output logic [irt_pkg::POSITION_BITS-1:0] freed_start_o,
  output logic [irt_pkg::POSITION_BITS-1:0] freed_end_o
);
  import irt_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0] state_q, state_d;

  // The stored ranges live in a memory with one registered read port, addressed
  // by the scan counter, and one write port used when a request finishes.
  logic [POSITION_BITS-1:0] mem_start [TABLE_SLOTS];
  logic [POSITION_BITS-1:0] mem_end   [TABLE_SLOTS];
  logic [POSITION_BITS-1:0] rd_start_q, rd_end_q;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;

  // Valid bits are flip-flops so that reset empties the table at once.
  logic [TABLE_SLOTS-1:0] slot_valid_q, slot_valid_d;

  // The request being worked on.
  logic                     op_q;
  logic [POSITION_BITS-1:0] req_start_q, req_end_q;

  // Scan control: addr_q is the address being read, and pend_q marks that the
  // read data for slot pidx_q arrives in this cycle.
  logic [CNT_W-1:0] addr_q, addr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;

  // Scan findings.
  logic                     ovl_q, ovl_d;
  logic                     match_q, match_d;
  logic [IDX_W-1:0]         match_idx_q, match_idx_d;
  logic                     free_q, free_d;
  logic [IDX_W-1:0]         free_idx_q, free_idx_d;
  logic                     hit_q, hit_d;
  logic [IDX_W-1:0]         hit_idx_q, hit_idx_d;
  logic [POSITION_BITS-1:0] hit_start_q, hit_start_d;
  logic [POSITION_BITS-1:0] hit_end_q, hit_end_d;

  // Result register.
  logic                     granted_q, granted_d;
  logic [POSITION_BITS-1:0] freed_start_q, freed_start_d;
  logic [POSITION_BITS-1:0] freed_end_q, freed_end_d;

  logic in_xfer;
  logic cur_valid;
  logic overlap;
  logic contains;
  logic alloc_ok;
  logic [IDX_W-1:0] alloc_idx;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_xfer       = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_RESP);
  assign granted_o     = granted_q;
  assign freed_start_o = freed_start_q;
  assign freed_end_o   = freed_end_q;

  // The shared slot comparator. A request [s,e] conflicts with a stored [S,E]
  // unless it ends before S or starts after E. A release position is held by
  // [S,E] when it lies between both bounds, so an inverted range holds nothing.
  assign cur_valid = slot_valid_q[pidx_q];
  assign overlap   = !((req_end_q < rd_start_q) || (req_start_q > rd_end_q));
  assign contains  = (req_start_q >= rd_start_q) && (req_start_q <= rd_end_q);

  // A granted allocate reuses the slot with the same start if there is one,
  // and otherwise takes the lowest free slot; with neither, the table is full.
  assign alloc_ok  = !ovl_q && (match_q || free_q);
  assign alloc_idx = match_q ? match_idx_q : free_idx_q;

  assign wr_en  = (state_q == ST_FINISH) && (op_q == OP_ALLOC) && alloc_ok;
  assign wr_idx = alloc_idx;

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    pend_d        = 1'b0;
    pidx_d        = pidx_q;
    ovl_d         = ovl_q;
    match_d       = match_q;
    match_idx_d   = match_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    hit_start_d   = hit_start_q;
    hit_end_d     = hit_end_q;
    slot_valid_d  = slot_valid_q;
    granted_d     = granted_q;
    freed_start_d = freed_start_q;
    freed_end_d   = freed_end_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SCAN;
          addr_d  = '0;
          ovl_d   = 1'b0;
          match_d = 1'b0;
          free_d  = 1'b0;
          hit_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous slot is being compared.
        if (addr_q < CNT_W'(TABLE_SLOTS)) begin
          pend_d = 1'b1;
          pidx_d = addr_q[IDX_W-1:0];
          addr_d = addr_q + CNT_W'(1);
        end else begin
          state_d = ST_FINISH;
        end

        if (pend_q) begin
          if (op_q == OP_ALLOC) begin
            if (cur_valid) begin
              if (overlap) begin
                ovl_d = 1'b1;
              end
              if ((rd_start_q == req_start_q) && !match_q) begin
                match_d     = 1'b1;
                match_idx_d = pidx_q;
              end
            end else if (!free_q) begin
              free_d     = 1'b1;
              free_idx_d = pidx_q;
            end
          end else begin
            if (cur_valid && contains && !hit_q) begin
              hit_d       = 1'b1;
              hit_idx_d   = pidx_q;
              hit_start_d = rd_start_q;
              hit_end_d   = rd_end_q;
            end
          end
        end
      end
      ST_FINISH: begin
        state_d       = ST_RESP;
        freed_start_d = '0;
        freed_end_d   = '0;
        if (op_q == OP_ALLOC) begin
          granted_d = alloc_ok;
          if (alloc_ok) begin
            slot_valid_d[alloc_idx] = 1'b1;
          end
        end else begin
          granted_d = hit_q;
          if (hit_q) begin
            freed_start_d           = hit_start_q;
            freed_end_d             = hit_end_q;
            slot_valid_d[hit_idx_q] = 1'b0;
          end
        end
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      addr_q       <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      addr_q       <= addr_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= op_i;
      req_start_q <= range_start_i;
      req_end_q   <= range_end_i;
    end
    pidx_q        <= pidx_d;
    ovl_q         <= ovl_d;
    match_q       <= match_d;
    match_idx_q   <= match_idx_d;
    free_q        <= free_d;
    free_idx_q    <= free_idx_d;
    hit_q         <= hit_d;
    hit_idx_q     <= hit_idx_d;
    hit_start_q   <= hit_start_d;
    hit_end_q     <= hit_end_d;
    granted_q     <= granted_d;
    freed_start_q <= freed_start_d;
    freed_end_q   <= freed_end_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[wr_idx] <= req_start_q;
      mem_end[wr_idx]   <= req_end_q;
    end
    rd_start_q <= mem_start[addr_q[IDX_W-1:0]];
    rd_end_q   <= mem_end[addr_q[IDX_W-1:0]];
  end

endmodule
